/* design/assert_macros.svh */
// assertion macros shared by the design files
// expects clk and rst_n in the scope of use; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ADHP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ADHP_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ADHP_ASSERT(label, prop, msg)

`define ADHP_NEVER(label, expr, msg)

`endif

`endif

/* design/adhp_pkg.sv */
// types and constants for the audio datagram header parser
// no dependencies
package adhp_pkg;

    localparam int COUNT_BITS = 18;
    localparam int CMP_W      = (COUNT_BITS > 18) ? COUNT_BITS : 18;
    localparam int OFF_W      = 17;

    localparam logic [31:0] MAGIC_RESET = 32'h4155_4450;
    localparam int BASE_HDR   = 10;
    localparam int LEN_BYTES  = 2;
    localparam int REF_BASE   = BASE_HDR + LEN_BYTES;
    localparam int MAGIC_END  = 4;
    localparam int SEQ_END    = 8;

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    typedef enum logic [2:0] {
        ERR_OK    = 3'd0,
        ERR_SHORT = 3'd1,
        ERR_MAGIC = 3'd2,
        ERR_NEAR  = 3'd3,
        ERR_REF   = 3'd4
    } err_code_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [31:0]           magic;
        logic [31:0]           seq;
        logic [15:0]           near_bytes;
        logic [15:0]           ref_len;
    } frame_t;

endpackage

/* design/audio_datagram_header_parser.sv */
// top level of the audio datagram header parser
// depends on adhp_pkg, adhp_frame, adhp_verdict and assert_macros.svh
//
// usage:
//   input channel (in_valid, in_stall, data_byte, last_byte) carries one
//   datagram byte per transaction, in arrival order, last_byte set on the
//   final byte. output channel (out_valid, out_stall, result fields) carries
//   one verdict transaction per datagram.
//   cfg_wr_en/cfg_wr_data write expected_magic; write only while idle.
//   throughput: one byte per cycle while in_stall is low; header capture is a counter and shift
//   registers updated in the accepting cycle.
//   result: the verdict is registered and appears in the cycle after the final byte is accepted.
//   reset: frame state clears, expected_magic returns to 0x41554450 and the
//   output register empties. no clearing pass is needed.
//   stall: while a verdict waits under out_stall, in_stall is raised and no
//   byte is taken; when the verdict is taken a new byte may be accepted in
//   the same cycle.
`include "assert_macros.svh"

module audio_datagram_header_parser
    import adhp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [31:0]      cfg_wr_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic             packet_ok,
    output logic [2:0]       error_code,
    output logic [31:0]      sequence_res,
    output logic [15:0]      near_length,
    output logic [15:0]      ref_length,
    output logic [OFF_W-1:0] ref_offset,
    output logic             ref_present
);

    logic [31:0] magic_reg;
    logic        accept;
    logic        fire;
    logic        take;
    logic        ok_out;
    frame_t      snap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg <= MAGIC_RESET;
        end
        else if (cfg_wr_en)
        begin
            magic_reg <= cfg_wr_data;
        end
    end

    assign in_stall = out_valid && out_stall;
    assign accept   = in_valid && !in_stall;
    assign fire     = accept && last_byte;
    assign take     = out_valid && !out_stall;
    assign ok_out   = out_valid && packet_ok;

    adhp_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .snap      (snap)
    );

    adhp_verdict u_verdict (
        .clk            (clk),
        .rst_n          (rst_n),
        .fire           (fire),
        .take           (take),
        .snap           (snap),
        .expected_magic (magic_reg),
        .res_valid      (out_valid),
        .packet_ok      (packet_ok),
        .error_code     (error_code),
        .sequence_res   (sequence_res),
        .near_length    (near_length),
        .ref_length     (ref_length),
        .ref_offset     (ref_offset),
        .ref_present    (ref_present)
    );

    `ADHP_ASSERT(a_last_gives_result, fire |=> out_valid, "final byte gave no verdict")
    `ADHP_NEVER(a_ok_code, out_valid && packet_ok != (error_code == ERR_OK), "packet_ok disagrees")
    `ADHP_NEVER(a_pres_ok, out_valid && ref_present && !packet_ok, "ref_present when failed")
    `ADHP_NEVER(a_off_zero, out_valid && !packet_ok && ref_offset != '0, "ref_offset when failed")
    `ADHP_NEVER(a_off_floor, ok_out && ref_offset <= OFF_W'(REF_BASE), "ref_offset too low")

endmodule

/* design/adhp_frame.sv */
// per-datagram capture: byte counter and header field shift registers
// depends on adhp_pkg
module adhp_frame
    import adhp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output frame_t     snap
);

    frame_t                frame_reg;
    frame_t                frame_next;
    logic [CMP_W-1:0]      pos_ext;
    logic [CMP_W-1:0]      ref_at;

    always_comb
    begin
        pos_ext = CMP_W'(frame_reg.count);
        ref_at  = CMP_W'(frame_reg.near_bytes) + CMP_W'(BASE_HDR);
        snap    = frame_reg;

        if (frame_reg.count < COUNT_BITS'(MAGIC_END))
        begin
            snap.magic = {frame_reg.magic[23:0], data_byte};
        end
        else if (frame_reg.count < COUNT_BITS'(SEQ_END))
        begin
            snap.seq = {frame_reg.seq[23:0], data_byte};
        end
        else if (frame_reg.count < COUNT_BITS'(BASE_HDR))
        begin
            snap.near_bytes = {frame_reg.near_bytes[7:0], data_byte};
        end
        else if (pos_ext == ref_at || pos_ext == ref_at + CMP_W'(1))
        begin
            snap.ref_len = {frame_reg.ref_len[7:0], data_byte};
        end

        if (frame_reg.count != CNT_MAX)
        begin
            snap.count = frame_reg.count + COUNT_BITS'(1);
        end

        frame_next = frame_reg;
        if (accept)
        begin
            frame_next = last_byte ? '0 : snap;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg <= '0;
        end
        else
        begin
            frame_reg <= frame_next;
        end
    end

endmodule

/* design/adhp_verdict.sv */
// datagram checks and the result register
// depends on adhp_pkg
module adhp_verdict
    import adhp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  logic             take,
    input  frame_t           snap,
    input  logic [31:0]      expected_magic,
    output logic             res_valid,
    output logic             packet_ok,
    output logic [2:0]       error_code,
    output logic [31:0]      sequence_res,
    output logic [15:0]      near_length,
    output logic [15:0]      ref_length,
    output logic [OFF_W-1:0] ref_offset,
    output logic             ref_present
);

    logic [CMP_W-1:0] n_ext;
    logic [CMP_W-1:0] hdr_end;
    logic [CMP_W-1:0] frame_end;

    err_code_t        code_next;
    logic [31:0]      seq_next;
    logic [15:0]      near_next;
    logic [15:0]      ref_next;
    logic [OFF_W-1:0] off_next;
    logic             pres_next;

    logic             valid_reg;
    logic             ok_reg;
    err_code_t        code_reg;
    logic [31:0]      seq_reg;
    logic [15:0]      near_reg;
    logic [15:0]      ref_reg;
    logic [OFF_W-1:0] off_reg;
    logic             pres_reg;

    always_comb
    begin
        n_ext     = CMP_W'(snap.count);
        hdr_end   = CMP_W'(snap.near_bytes) + CMP_W'(REF_BASE);
        frame_end = hdr_end + CMP_W'(snap.ref_len);

        code_next = ERR_OK;
        seq_next  = '0;
        near_next = '0;
        ref_next  = '0;
        off_next  = '0;
        pres_next = 1'b0;

        if (n_ext < CMP_W'(BASE_HDR))
        begin
            code_next = ERR_SHORT;
        end
        else if (snap.magic != expected_magic)
        begin
            code_next = ERR_MAGIC;
        end
        else
        begin
            seq_next  = snap.seq;
            near_next = snap.near_bytes;
            if (snap.near_bytes == 16'd0 || n_ext < hdr_end)
            begin
                code_next = ERR_NEAR;
            end
            else
            begin
                ref_next = snap.ref_len;
                if (n_ext < frame_end)
                begin
                    code_next = ERR_REF;
                end
                else
                begin
                    off_next  = hdr_end[OFF_W-1:0];
                    pres_next = (snap.ref_len != 16'd0);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            ok_reg   <= (code_next == ERR_OK);
            code_reg <= code_next;
            seq_reg  <= seq_next;
            near_reg <= near_next;
            ref_reg  <= ref_next;
            off_reg  <= off_next;
            pres_reg <= pres_next;
        end
    end

    assign res_valid    = valid_reg;
    assign packet_ok    = ok_reg;
    assign error_code   = code_reg;
    assign sequence_res = seq_reg;
    assign near_length  = near_reg;
    assign ref_length   = ref_reg;
    assign ref_offset   = off_reg;
    assign ref_present  = pres_reg;

endmodule

/* tb/sv/tb_audio_datagram_header_parser.sv */
`timescale 1ns / 100ps
// testbench for audio_datagram_header_parser: directed and random datagrams, scoreboarded verdicts
// depends on adhp_pkg and the design files; self-contained otherwise
module tb_audio_datagram_header_parser;

    import adhp_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } dgram_byte_t;

    typedef struct packed {
        logic             ok;
        err_code_t        code;
        logic [31:0]      seq;
        logic [15:0]      near_bytes;
        logic [15:0]      ref_len;
        logic [OFF_W-1:0] ref_off;
        logic             ref_pres;
    } verdict_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [31:0]      cfg_wr_data = '0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [7:0]       data_byte = '0;
    logic             last_byte = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic             packet_ok;
    logic [2:0]       error_code;
    logic [31:0]      sequence_res;
    logic [15:0]      near_length;
    logic [15:0]      ref_length;
    logic [OFF_W-1:0] ref_offset;
    logic             ref_present;

    dgram_byte_t pending_bytes[$];
    verdict_t    verdicts[$];
    int unsigned send_idle_pct = 34;
    int unsigned recv_idle_pct = 50;
    int unsigned mismatch_count = 0;

    // header capture mirror
    logic [31:0]           magic_cfg = MAGIC_RESET;
    logic [COUNT_BITS-1:0] frm_count = '0;
    logic [31:0]           frm_magic = '0;
    logic [31:0]           frm_seq = '0;
    logic [15:0]           frm_near = '0;
    logic [15:0]           frm_ref = '0;

    audio_datagram_header_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .packet_ok    (packet_ok),
        .error_code   (error_code),
        .sequence_res (sequence_res),
        .near_length  (near_length),
        .ref_length   (ref_length),
        .ref_offset   (ref_offset),
        .ref_present  (ref_present)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic parse_byte(input logic [7:0] b, input logic lst);
        int unsigned pos;
        int unsigned n;
        int unsigned ref_at;
        verdict_t    v;
        pos = 32'(frm_count);
        if (pos < MAGIC_END)
            frm_magic = {frm_magic[23:0], b};
        else if (pos < SEQ_END)
            frm_seq = {frm_seq[23:0], b};
        else if (pos < BASE_HDR)
            frm_near = {frm_near[7:0], b};
        else
        begin
            ref_at = BASE_HDR + frm_near;
            if (pos == ref_at || pos == ref_at + 1)
                frm_ref = {frm_ref[7:0], b};
        end
        if (frm_count != CNT_MAX)
            frm_count = frm_count + 1'b1;
        if (lst)
        begin
            n = 32'(frm_count);
            v = '0;
            v.code = ERR_OK;
            if (n < BASE_HDR)
                v.code = ERR_SHORT;
            else if (frm_magic != magic_cfg)
                v.code = ERR_MAGIC;
            else
            begin
                v.seq = frm_seq;
                v.near_bytes = frm_near;
                if (frm_near == 0 || n < REF_BASE + frm_near)
                    v.code = ERR_NEAR;
                else
                begin
                    v.ref_len = frm_ref;
                    if (n < REF_BASE + frm_near + frm_ref)
                        v.code = ERR_REF;
                    else
                    begin
                        v.ok = 1'b1;
                        v.ref_off = OFF_W'(REF_BASE + frm_near);
                        v.ref_pres = (frm_ref != 0);
                    end
                end
            end
            verdicts.push_back(v);
            frm_count = '0;
            frm_magic = '0;
            frm_seq = '0;
            frm_near = '0;
            frm_ref = '0;
        end
    endtask

    task automatic check_field(input string fname, input logic [31:0] want_v,
                               input logic [31:0] got_v);
        if (got_v !== want_v)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%s mismatch: expected %0h, got %0h", fname, want_v, got_v);
        end
    endtask

    task automatic check_verdict();
        verdict_t want;
        if (verdicts.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("verdict with none pending: error_code %0d", error_code);
        end
        else
        begin
            want = verdicts.pop_front();
            check_field("packet_ok", 32'(want.ok), 32'(packet_ok));
            check_field("error_code", 32'(want.code), 32'(error_code));
            check_field("sequence_res", want.seq, sequence_res);
            check_field("near_length", 32'(want.near_bytes), 32'(near_length));
            check_field("ref_length", 32'(want.ref_len), 32'(ref_length));
            check_field("ref_offset", 32'(want.ref_off), 32'(ref_offset));
            check_field("ref_present", 32'(want.ref_pres), 32'(ref_present));
        end
    endtask

    // driver: one byte per transaction, payload held while stalled
    always @(posedge clk)
    begin : byte_driver
        dgram_byte_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                parse_byte(data_byte, last_byte);
            if (!in_valid || !in_stall)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = pending_bytes.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= nxt.data;
                    last_byte <= nxt.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: checks each verdict transaction, stalls at random
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            check_verdict();
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic add_datagram(input logic [31:0] mg, input logic [31:0] sq,
                                input logic [15:0] nl, input logic [15:0] rl,
                                input int unsigned len);
        dgram_byte_t item;
        int unsigned ref_at;
        ref_at = BASE_HDR + nl;
        for (int unsigned i = 0; i < len; i++)
        begin
            if (i < MAGIC_END)
                item.data = 8'(mg >> (24 - 8 * i));
            else if (i < SEQ_END)
                item.data = 8'(sq >> (56 - 8 * i));
            else if (i < BASE_HDR)
                item.data = 8'(nl >> (72 - 8 * i));
            else if (i == ref_at)
                item.data = rl[15:8];
            else if (i == ref_at + 1)
                item.data = rl[7:0];
            else
                item.data = 8'($urandom);
            item.last = (i == len - 1);
            pending_bytes.push_back(item);
        end
    endtask

    task automatic add_random_datagram(output int unsigned len);
        logic [31:0] mg;
        logic [31:0] sq;
        logic [15:0] nl;
        logic [15:0] rl;
        int unsigned kind;
        int unsigned full;
        mg = magic_cfg;
        sq = $urandom;
        nl = 16'($urandom_range(24, 1));
        rl = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom_range(24, 1));
        full = REF_BASE + nl + rl;
        kind = $urandom_range(99);
        if (kind < 55)
            len = full + (($urandom_range(3) == 0) ? $urandom_range(6, 1) : 0);
        else if (kind < 67)
        begin
            // truncated reference part
            rl = ($urandom_range(4) == 0) ? 16'($urandom_range(65535, 1))
                                          : 16'($urandom_range(24, 1));
            len = REF_BASE + nl + $urandom_range((rl > 30) ? 30 : rl - 1);
        end
        else if (kind < 77)
        begin
            case ($urandom_range(2))
                0:
                begin
                    nl = '0;
                    len = $urandom_range(30, BASE_HDR);
                end
                1: len = $urandom_range(REF_BASE - 1 + nl, BASE_HDR);
                default:
                begin
                    nl = 16'($urandom_range(65535, 25));
                    len = $urandom_range(40, BASE_HDR);
                end
            endcase
        end
        else if (kind < 85)
        begin
            mg = magic_cfg ^ (32'h1 << $urandom_range(31));
            len = $urandom_range(full + 4, BASE_HDR);
        end
        else if (kind < 92)
            len = $urandom_range(BASE_HDR - 1, 1);
        else
        begin
            mg = $urandom;
            nl = 16'($urandom);
            rl = 16'($urandom);
            len = $urandom_range(40, 1);
        end
        add_datagram(mg, sq, nl, rl, len);
    endtask

    task automatic add_random_phase(input int unsigned budget);
        int unsigned phase_bytes;
        int unsigned len;
        phase_bytes = 0;
        while (phase_bytes < budget)
        begin
            add_random_datagram(len);
            phase_bytes += len;
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_bytes.size() != 0 || in_valid || verdicts.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_magic(input logic [31:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        magic_cfg = value;
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed datagrams under the reset magic
        @(negedge clk);
        add_datagram(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1);
        add_datagram(MAGIC_RESET, 32'h0000_0000, 16'd4, 16'd0, 9);
        add_datagram(MAGIC_RESET, 32'hFFFF_FFFF, 16'd0, 16'd0, 10);
        add_datagram(MAGIC_RESET ^ 32'h8000_0000, 32'h1234_5678, 16'd1, 16'd0, 13);
        add_datagram(MAGIC_RESET, 32'h0000_0001, 16'd3, 16'd0, 14);
        add_datagram(MAGIC_RESET, 32'h8000_0000, 16'd2, 16'd3, 16);
        add_datagram(MAGIC_RESET, 32'hA5A5_5A5A, 16'd1, 16'd0, 13);
        add_datagram(MAGIC_RESET, 32'h0F0F_F0F0, 16'd2, 16'd2, 20);
        add_datagram(MAGIC_RESET, 32'h7FFF_FFFF, 16'hFFFF, 16'd0, 10);
        add_datagram(MAGIC_RESET, 32'h0000_FFFF, 16'd1, 16'hFFFF, 14);
        wait_drained();

        write_magic($urandom);
        @(negedge clk);
        add_random_phase(330);
        wait_drained();

        send_idle_pct = 50;
        recv_idle_pct = 34;
        write_magic(32'hFFFF_FFFF);
        @(negedge clk);
        add_random_phase(330);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_magic(32'h0000_0000);
        @(negedge clk);
        add_random_phase(320);
        // longest near and reference lengths on a short datagram, then an exact-length datagram
        add_datagram(magic_cfg, $urandom, 16'hFFFF, 16'hFFFF, 40);
        add_datagram(magic_cfg, $urandom, 16'd3, 16'd2, 17);
        wait_drained();

        if (mismatch_count == 0 && verdicts.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
+incdir+design
design/adhp_pkg.sv
design/adhp_frame.sv
design/adhp_verdict.sv
design/audio_datagram_header_parser.sv
tb/sv/tb_audio_datagram_header_parser.sv
